>>> rtl/sts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the segment tree range sum unit.
// Depends on nothing; every other file of the block imports it.
package sts_pkg;

    localparam int DEF_LEAVES = 1024;
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ULEAF,
        ST_URD,
        ST_UWR,
        ST_QRD,
        ST_QACC,
        ST_QDONE
    } sts_state_t;

endpackage

>>> rtl/segment_tree_range_sum_unit.sv
`timescale 1ns / 1ps
// Segment tree range sum unit: point update and inclusive range sum query.
// Depends on sts_pkg, sts_ctrl and sts_mem.
//
// After reset the unit clears all 2*P words of its tree store (P is LEAVES
// rounded up to a power of two, at least 2; 2048 words for 1024 leaves), with
// busy high. A word is taken when start is high and busy is low. An update
// gives no result. Both operations walk the tree one level at a time through
// the single tree store. done is high for exactly one cycle with the query
// result on range_sum; the receiver cannot stall it.
module segment_tree_range_sum_unit #(
    parameter int LEAVES = sts_pkg::DEF_LEAVES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [sts_pkg::IDX_W-1:0]         first_index,
    input  logic [sts_pkg::IDX_W-1:0]         last_index,
    input  logic signed [sts_pkg::DATA_W-1:0] new_value,
    output logic                              done,
    output logic signed [sts_pkg::DATA_W-1:0] range_sum
);
    import sts_pkg::*;

    localparam int LOG = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int AW  = LOG + 1;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr_a;
    logic [AW-1:0]     mem_raddr_b;
    logic [DATA_W-1:0] mem_rdata_a;
    logic [DATA_W-1:0] mem_rdata_b;
    logic [DATA_W-1:0] sum;

    sts_ctrl #(
        .LEAVES (LEAVES),
        .AW     (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .first_index (first_index),
        .last_index  (last_index),
        .new_value   (new_value),
        .busy        (busy),
        .done        (done),
        .sum         (sum),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    sts_mem #(
        .AW (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign range_sum = sum;

endmodule

>>> rtl/sts_mem.sv
`timescale 1ns / 1ps
// Tree sum store: one write port and two read ports with registered read data.
// Depends on sts_pkg for the data width.
module sts_mem #(
    parameter int AW = 11
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [sts_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]             raddr_a,
    input  logic [AW-1:0]             raddr_b,
    output logic [sts_pkg::DATA_W-1:0] rdata_a,
    output logic [sts_pkg::DATA_W-1:0] rdata_b
);
    import sts_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic [DATA_W-1:0] ram_reg [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_a_reg <= ram_reg[raddr_a];
        rdata_b_reg <= ram_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/sts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the segment tree: clearing pass, leaf-to-root update walk and
// bottom-up range query. Depends on sts_pkg; drives the ports of sts_mem.
module sts_ctrl #(
    parameter int LEAVES = sts_pkg::DEF_LEAVES,
    parameter int AW     = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        opcode,
    input  logic [sts_pkg::IDX_W-1:0]   first_index,
    input  logic [sts_pkg::IDX_W-1:0]   last_index,
    input  logic [sts_pkg::DATA_W-1:0]  new_value,
    output logic                        busy,
    output logic                        done,
    output logic [sts_pkg::DATA_W-1:0]  sum,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [sts_pkg::DATA_W-1:0]  mem_wdata,
    output logic [AW-1:0]               mem_raddr_a,
    output logic [AW-1:0]               mem_raddr_b,
    input  logic [sts_pkg::DATA_W-1:0]  mem_rdata_a,
    input  logic [sts_pkg::DATA_W-1:0]  mem_rdata_b
);
    import sts_pkg::*;

    localparam int LOG = AW - 1;
    localparam int P   = 2 ** LOG;
    localparam int LW  = (LOG > IDX_W) ? LOG : IDX_W;
    localparam logic [LW-1:0] LAST_LEAF = LW'(LEAVES - 1);

    sts_state_t        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [AW:0]       lo_reg, lo_next;
    logic [AW:0]       hi_reg, hi_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] value_reg, value_next;

    logic [LW-1:0] first_ext;
    logic [LW-1:0] last_ext;
    logic [LW-1:0] last_clip;
    logic          first_ok;
    logic          range_ok;
    logic [AW:0]   hi_m1;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;

    assign first_ext = LW'(first_index);
    assign last_ext  = LW'(last_index);
    assign last_clip = (last_ext > LAST_LEAF) ? LAST_LEAF : last_ext;
    assign first_ok  = (first_ext <= LAST_LEAF);
    assign range_ok  = (first_ext <= last_clip);
    assign hi_m1     = hi_reg - (AW + 1)'(1);
    assign add_a     = lo_reg[0] ? mem_rdata_a : '0;
    assign add_b     = hi_reg[0] ? mem_rdata_b : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        state_next = ST_QRD;
                    end
                    else if (first_ok)
                    begin
                        state_next = ST_ULEAF;
                    end
                end
            end
            ST_ULEAF: state_next = ST_URD;
            ST_URD:   state_next = ST_UWR;
            ST_UWR:
            begin
                state_next = (node_reg == AW'(1)) ? ST_IDLE : ST_URD;
            end
            ST_QRD:
            begin
                state_next = (lo_reg < hi_reg) ? ST_QACC : ST_QDONE;
            end
            ST_QACC:  state_next = ST_QRD;
            ST_QDONE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next   = clr_reg;
        node_next  = node_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        sum_next   = sum_reg;
        value_next = value_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                value_next = new_value;
                sum_next   = '0;
                if (opcode == OP_QUERY && !range_ok)
                begin
                    lo_next = '0;
                    hi_next = '0;
                end
                else
                begin
                    lo_next = (AW + 1)'(P) + (AW + 1)'(first_ext);
                    hi_next = (AW + 1)'(P) + (AW + 1)'(last_clip) + (AW + 1)'(1);
                end
            end
            ST_ULEAF:
            begin
                node_next = {1'b0, lo_reg[AW-1:1]};
            end
            ST_UWR:
            begin
                node_next = {1'b0, node_reg[AW-1:1]};
            end
            ST_QACC:
            begin
                sum_next = sum_reg + add_a + add_b;
                lo_next  = (lo_reg + (AW + 1)'(lo_reg[0])) >> 1;
                hi_next  = hi_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        done        = (state_reg == ST_QDONE);
        mem_we      = 1'b0;
        mem_waddr   = clr_reg;
        mem_wdata   = '0;
        mem_raddr_a = lo_reg[AW-1:0];
        mem_raddr_b = hi_m1[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_ULEAF:
            begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[AW-1:0];
                mem_wdata = value_reg;
            end
            ST_URD:
            begin
                mem_raddr_a = {node_reg[AW-2:0], 1'b0};
                mem_raddr_b = {node_reg[AW-2:0], 1'b1};
            end
            ST_UWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = node_reg;
                mem_wdata = mem_rdata_a + mem_rdata_b;
            end
            default:
            begin
            end
        endcase
    end

    assign sum = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        sum_reg   <= sum_next;
        value_reg <= value_next;
    end

endmodule

>>> test/segment_tree_range_sum_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_tree_range_sum_unit: directed and random
// update and query words, checked against a flat element array.
// Depends on sts_pkg and the segment_tree_range_sum_unit RTL.
module segment_tree_range_sum_unit_test;
    import sts_pkg::*;

    localparam int LEAVES     = DEF_LEAVES;
    localparam int RAND_WORDS = 1600;
    localparam int DRAIN_CYC  = 64;

    typedef struct {
        logic                     opcode;
        logic [IDX_W-1:0]         first_index;
        logic [IDX_W-1:0]         last_index;
        logic signed [DATA_W-1:0] new_value;
    } tree_cmd_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     opcode      = OP_UPDATE;
    logic [IDX_W-1:0]         first_index = '0;
    logic [IDX_W-1:0]         last_index  = '0;
    logic signed [DATA_W-1:0] new_value   = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] range_sum;

    logic signed [DATA_W-1:0] element_values [0:LEAVES-1];
    logic signed [DATA_W-1:0] expected_sums [$];
    tree_cmd_t                pending_cmds [$];
    tree_cmd_t                active_cmd;
    int                       burst_left  = 4;
    int                       gap_left    = 0;
    int                       error_count = 0;

    segment_tree_range_sum_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .first_index (first_index),
        .last_index  (last_index),
        .new_value   (new_value),
        .done        (done),
        .range_sum   (range_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] sum_of_elements(
        input logic [IDX_W-1:0] lo_idx,
        input logic [IDX_W-1:0] hi_idx
    );
        logic signed [DATA_W-1:0] acc;
        int                       top;
        acc = '0;
        top = (int'(hi_idx) < LEAVES) ? int'(hi_idx) : LEAVES - 1;
        for (int i = int'(lo_idx); i <= top; i++)
            acc = acc + element_values[i];
        return acc;
    endfunction

    task automatic apply_tree_cmd(input tree_cmd_t cmd);
        if (cmd.opcode == OP_UPDATE)
        begin
            if (int'(cmd.first_index) < LEAVES)
                element_values[cmd.first_index] = cmd.new_value;
        end
        else
        begin
            expected_sums.push_back(sum_of_elements(cmd.first_index, cmd.last_index));
        end
    endtask

    task automatic queue_cmd(
        input logic                     op,
        input logic [IDX_W-1:0]         lo_idx,
        input logic [IDX_W-1:0]         hi_idx,
        input logic signed [DATA_W-1:0] value
    );
        tree_cmd_t cmd;
        cmd.opcode      = op;
        cmd.first_index = lo_idx;
        cmd.last_index  = hi_idx;
        cmd.new_value   = value;
        pending_cmds.push_back(cmd);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_edge_index();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd511;
            3: return 10'd512;
            4: return 10'd1022;
            default: return 10'd1023;
        endcase
    endfunction

    task automatic queue_random_cmds(input int count);
        logic             op;
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
        logic [IDX_W-1:0] swap_idx;
        for (int n = 0; n < count; n++)
        begin
            op     = ($urandom_range(0, 99) < 40) ? OP_UPDATE : OP_QUERY;
            lo_idx = IDX_W'($urandom_range(0, LEAVES - 1));
            hi_idx = IDX_W'($urandom_range(0, LEAVES - 1));
            case ($urandom_range(0, 9))
                6:
                begin
                    hi_idx = (int'(lo_idx) + 7 < LEAVES) ?
                             lo_idx + IDX_W'($urandom_range(0, 7)) : IDX_W'(LEAVES - 1);
                end
                7:
                begin
                    if (lo_idx == 0)
                        lo_idx = 10'd1;
                    hi_idx = IDX_W'($urandom_range(0, int'(lo_idx) - 1));
                end
                8:
                begin
                    lo_idx = pick_edge_index();
                    hi_idx = pick_edge_index();
                end
                9:
                begin
                end
                default:
                begin
                    if (lo_idx > hi_idx)
                    begin
                        swap_idx = lo_idx;
                        lo_idx   = hi_idx;
                        hi_idx   = swap_idx;
                    end
                end
            endcase
            queue_cmd(op, lo_idx, hi_idx, pick_value());
        end
    endtask

    always @(posedge clk)
    begin : word_driver
        tree_cmd_t next_cmd;
        logic      next_start;
        if (rst_n)
        begin
            next_start = start;
            if (start && !busy)
            begin
                apply_tree_cmd(active_cmd);
                next_start = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = $urandom_range(1, 24);
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 8);
                end
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_cmd    = pending_cmds.pop_front();
                    active_cmd  = next_cmd;
                    opcode      <= next_cmd.opcode;
                    first_index <= next_cmd.first_index;
                    last_index  <= next_cmd.last_index;
                    new_value   <= next_cmd.new_value;
                    next_start  = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        logic signed [DATA_W-1:0] want;
        if (rst_n && done)
        begin
            if (expected_sums.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result range_sum=%0d", range_sum));
            end
            else
            begin
                want = expected_sums.pop_front();
                if (range_sum !== want)
                    report_mismatch($sformatf("range_sum=%0d, expected %0d", range_sum, want));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < LEAVES; i++)
            element_values[i] = '0;

        // The whole array reads as zero after the clearing pass.
        queue_cmd(OP_QUERY, 10'd0, 10'd1023, 32'sh7FFF_FFFF);
        queue_cmd(OP_UPDATE, 10'd0, 10'd1023, 32'sh7FFF_FFFF);
        queue_cmd(OP_UPDATE, 10'd1023, 10'd0, 32'sh8000_0000);
        queue_cmd(OP_UPDATE, 10'd511, 10'd5, 32'sd12345);
        queue_cmd(OP_UPDATE, 10'd512, 10'd0, -32'sd678);
        queue_cmd(OP_UPDATE, 10'd1, 10'd0, -32'sd1);
        queue_cmd(OP_QUERY, 10'd0, 10'd0, -32'sd1);
        queue_cmd(OP_QUERY, 10'd1023, 10'd1023, 32'sd0);
        queue_cmd(OP_QUERY, 10'd0, 10'd1023, 32'sd0);
        queue_cmd(OP_QUERY, 10'd511, 10'd512, 32'sd0);
        queue_cmd(OP_QUERY, 10'd0, 10'd511, 32'sd0);
        queue_cmd(OP_QUERY, 10'd512, 10'd1023, 32'sd0);
        // Empty ranges must give zero even over nonzero elements.
        queue_cmd(OP_QUERY, 10'd5, 10'd3, 32'sd0);
        queue_cmd(OP_QUERY, 10'd1023, 10'd0, 32'sd0);
        queue_cmd(OP_QUERY, 10'd1, 10'd0, 32'sd0);
        // Two large positives wrap past the top of the signed range.
        queue_cmd(OP_UPDATE, 10'd2, 10'd1023, 32'sh7FFF_FFFF);
        queue_cmd(OP_QUERY, 10'd0, 10'd2, 32'sd0);
        queue_cmd(OP_UPDATE, 10'd0, 10'd0, 32'sd7);
        queue_cmd(OP_QUERY, 10'd0, 10'd2, 32'sd0);
        queue_cmd(OP_QUERY, 10'd2, 10'd511, 32'sd0);
        queue_cmd(OP_QUERY, 10'd1, 10'd1022, 32'sd0);

        queue_random_cmds(RAND_WORDS);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (expected_sums.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (error_count == 0)
            $display("segment_tree_range_sum_unit_test OK");
        else
            $display("segment_tree_range_sum_unit_test NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ERROR: timeout");
        $display("segment_tree_range_sum_unit_test NOT OK");
        $finish;
    end

endmodule
